>>> rtl/cpx_pkg.sv
// Shared types and constants for the charlieplexed LED PWM scanner.
// Defines the command opcodes and the result record.
// No dependencies.
`timescale 1ns / 1ps

package cpx_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int LED_NUM_W = 6;
    localparam int DUTY_W    = 8;
    localparam int PIN_OUT_W = 3;
    localparam int PC_W      = 4;

    typedef struct packed {
        logic                 lit;
        logic [PIN_OUT_W-1:0] high_pin;
        logic [PIN_OUT_W-1:0] low_pin;
        logic [LED_NUM_W-1:0] current_led;
        logic                 is_paused;
        logic                 bad_index;
    } t_res;

endpackage

>>> rtl/cpx_cmd_if.sv
// Request channel of the scanner: valid/ready handshake and command fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface cpx_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [5:0] led_number;
    logic [7:0] duty_value;
    logic       pause_request;

    modport source (output valid, opcode, led_number, duty_value, pause_request,
                    input ready);
    modport sink (input valid, opcode, led_number, duty_value, pause_request,
                  output ready);
endinterface

>>> rtl/cpx_res_if.sv
// Result channel of the scanner: valid/ready handshake and status fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface cpx_res_if;
    logic       valid;
    logic       ready;
    logic       lit;
    logic [2:0] high_pin;
    logic [2:0] low_pin;
    logic [5:0] current_led;
    logic       is_paused;
    logic       bad_index;

    modport source (output valid, lit, high_pin, low_pin, current_led, is_paused,
                    bad_index, input ready);
    modport sink (input valid, lit, high_pin, low_pin, current_led, is_paused,
                  bad_index, output ready);
endinterface

>>> rtl/charlieplex_pwm_scanner.sv
// Charlieplexed LED PWM scan driver: duty store, slot timer and scan pointer.
// Depends on cpx_pkg, cpx_cmd_if, cpx_res_if and cpx_out_buf.
// A result is registered in the output buffer, or parked in its skid stage while held.
// Throughput: one request per cycle while the output buffer is ready; the duty of the next
// LED is prefetched from the duty memory every cycle, so slot changes never stall.
// Reset (synchronous, active low) clears all control state and the per-entry
// valid bits of the duty memory at once; there is no clearing pass.
`timescale 1ns / 1ps

module charlieplex_pwm_scanner #(
    parameter int MAX_PINS = 8,
    parameter int DUTY_TOP = 255
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [cpx_pkg::PC_W-1:0] i_cfg_data,
    cpx_cmd_if.sink                 i_cmd,
    cpx_res_if.source               o_res
);
    import cpx_pkg::*;

    localparam int DEPTH = MAX_PINS * (MAX_PINS - 1);
    localparam int W     = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = $clog2(MAX_PINS);
    localparam int PCW   = $clog2(MAX_PINS + 1);
    localparam int PXW   = (PCW > PC_W) ? PCW : PC_W;
    localparam int CMPW  = (CW > LED_NUM_W) ? CW : LED_NUM_W;
    localparam logic [PC_W-1:0] PC_RESET = PC_W'(8);

    // Clamp the pin count to the supported range.
    function automatic logic [PCW-1:0] pins_used(input logic [PC_W-1:0] raw);
        logic [PXW-1:0] rx;
        logic [PXW-1:0] p;
        rx = PXW'(raw);
        p  = rx;
        if (rx < PXW'(2)) begin
            p = PXW'(2);
        end else if (rx > PXW'(MAX_PINS)) begin
            p = PXW'(MAX_PINS);
        end
        return PCW'(p);
    endfunction

    function automatic logic [CW-1:0] led_total(input logic [PC_W-1:0] raw);
        logic [CW-1:0] p;
        p = CW'(pins_used(raw));
        return CW'(p * (p - CW'(1)));
    endfunction

    function automatic logic [PW-1:0] span_of(input logic [PC_W-1:0] raw);
        return PW'(pins_used(raw) - PCW'(1));
    endfunction

    function automatic logic [W-1:0] wrap_inc(input logic [W-1:0] idx,
                                              input logic [CW-1:0] total);
        logic [CW-1:0] s;
        s = CW'(idx) + CW'(1);
        return (s >= total) ? W'(0) : W'(s);
    endfunction

    // High pin is the quotient by span, found by comparing against each multiple.
    function automatic logic [2*PW-1:0] place_pins(input logic [W-1:0] idx,
                                                   input logic [PW-1:0] span);
        logic [PW-1:0] h;
        logic [CW-1:0] rem;
        logic [PW-1:0] l;
        h = '0;
        for (int k = 1; k < MAX_PINS; k++) begin
            if (CW'(CW'(k) * CW'(span)) <= CW'(idx)) begin
                h = h + PW'(1);
            end
        end
        rem = CW'(idx) - CW'(CW'(h) * CW'(span));
        l   = PW'(rem);
        if (l >= h) begin
            l = l + PW'(1);
        end
        return {h, l};
    endfunction

    logic [DUTY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DUTY_W-1:0] r_rd;

    logic [DUTY_W-1:0] r_slot,  n_slot;
    logic [W-1:0]      r_scan,  n_scan;
    logic [W-1:0]      r_next,  n_next;
    logic [PW-1:0]     r_high,  n_high;
    logic [PW-1:0]     r_low,   n_low;
    logic [DUTY_W-1:0] r_latch, n_latch;
    logic              r_on,    n_on;
    logic              r_pd,    n_pd;
    logic [PW-1:0]     r_span,  n_span;
    logic [CW-1:0]     r_total, n_total;

    logic              acc;
    logic              wr_en;
    logic              clr;
    logic              bad;
    logic [W-1:0]      wr_addr;
    logic [W-1:0]      rd_addr;
    logic [DUTY_W-1:0] duty_next;
    logic [2*PW-1:0]   next_pins;
    logic [DUTY_W-1:0] tick_val;
    logic              buf_ready;
    t_res              res_in;
    t_res              res_out;

    assign acc       = i_cmd.valid && buf_ready;
    assign i_cmd.ready = buf_ready;
    assign wr_addr   = W'(i_cmd.led_number);
    assign next_pins = place_pins(r_next, r_span);
    assign tick_val  = r_slot + DUTY_W'(1);
    // Prefetched duty of the next LED; entries not written since a clear read zero.
    assign duty_next = r_vld[r_next] ? r_rd : '0;
    assign rd_addr   = i_rst_n ? n_next : W'(1);

    always_comb begin
        n_slot  = r_slot;
        n_scan  = r_scan;
        n_next  = r_next;
        n_high  = r_high;
        n_low   = r_low;
        n_latch = r_latch;
        n_on    = r_on;
        n_pd    = r_pd;
        n_span  = r_span;
        n_total = r_total;
        wr_en   = 1'b0;
        clr     = 1'b0;
        bad     = 1'b0;
        if (acc) begin
            unique case (i_cmd.opcode)
                OP_TICK: begin
                    if (tick_val == r_latch || (i_cmd.pause_request && !r_pd)) begin
                        n_on = 1'b0;
                    end
                    n_pd = i_cmd.pause_request;
                    if (tick_val >= DUTY_W'(DUTY_TOP)) begin
                        n_slot  = '0;
                        n_scan  = r_next;
                        n_next  = wrap_inc(r_next, r_total);
                        n_high  = next_pins[2*PW-1:PW];
                        n_low   = next_pins[PW-1:0];
                        n_latch = i_cmd.pause_request ? '0 : duty_next;
                        n_on    = n_latch != '0;
                    end else begin
                        n_slot = tick_val;
                    end
                end
                OP_SET: begin
                    if (CMPW'(i_cmd.led_number) < CMPW'(r_total)) begin
                        wr_en = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    clr = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (i_cfg_we) begin
            n_span  = span_of(i_cfg_data);
            n_total = led_total(i_cfg_data);
            n_next  = wrap_inc(r_scan, led_total(i_cfg_data));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_scan  <= '0;
            r_next  <= W'(1);
            r_high  <= '0;
            r_low   <= PW'(1);
            r_latch <= '0;
            r_on    <= 1'b0;
            r_pd    <= 1'b0;
            r_span  <= span_of(PC_RESET);
            r_total <= led_total(PC_RESET);
            r_vld   <= '0;
        end else begin
            r_slot  <= n_slot;
            r_scan  <= n_scan;
            r_next  <= n_next;
            r_high  <= n_high;
            r_low   <= n_low;
            r_latch <= n_latch;
            r_on    <= n_on;
            r_pd    <= n_pd;
            r_span  <= n_span;
            r_total <= n_total;
            if (clr) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Duty memory: one write port, one registered read port with write forwarding.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.duty_value;
        end
        if (wr_en && wr_addr == rd_addr) begin
            r_rd <= i_cmd.duty_value;
        end else begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_comb begin
        res_in.lit         = n_on;
        res_in.high_pin    = PIN_OUT_W'(n_high);
        res_in.low_pin     = PIN_OUT_W'(n_low);
        res_in.current_led = LED_NUM_W'(n_scan);
        res_in.is_paused   = n_pd;
        res_in.bad_index   = bad;
    end

    cpx_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .o_ready (buf_ready),
        .i_data  (res_in),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (res_out)
    );

    assign o_res.lit         = res_out.lit;
    assign o_res.high_pin    = res_out.high_pin;
    assign o_res.low_pin     = res_out.low_pin;
    assign o_res.current_led = res_out.current_led;
    assign o_res.is_paused   = res_out.is_paused;
    assign o_res.bad_index   = res_out.bad_index;

endmodule

>>> rtl/cpx_out_buf.sv
// Two-entry output register with skid stage for scanner results.
// Depends on cpx_pkg.
`timescale 1ns / 1ps

module cpx_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cpx_pkg::t_res i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cpx_pkg::t_res o_data
);
    import cpx_pkg::*;

    logic r_valid;
    logic r_skid_valid;
    t_res r_data;
    t_res r_skid_data;
    logic pop;
    logic push;

    assign pop     = r_valid && i_ready;
    assign push    = i_valid && !r_skid_valid;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_valid && !pop) begin
            // Main register is held; a new result parks in the skid stage.
            if (push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_valid      <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid && !pop) begin
            if (push) begin
                r_skid_data <= i_data;
            end
        end else if (r_skid_valid) begin
            r_data <= r_skid_data;
        end else begin
            r_data <= i_data;
        end
    end

endmodule
